// File: rtl/chsp_pkg.sv
// Shared types and constants for the chunk header stream parser.
package chsp_pkg;

	localparam int QUEUE_DEPTH_DEFAULT = 4;

	localparam logic [7:0] VERSION_OLD   = 8'd2;
	localparam logic [7:0] VERSION_NEW   = 8'd3;
	localparam logic [7:0] TYPE_WAVEFORM = 8'd1;

	typedef enum logic [3:0] {
		PH_VER   = 4'd0,
		PH_SIZE  = 4'd1,
		PH_TYPE  = 4'd2,
		PH_FAM   = 4'd3,
		PH_FVER  = 4'd4,
		PH_EXT   = 4'd5,
		PH_SID   = 4'd6,
		PH_TIME  = 4'd7,
		PH_ICNT  = 4'd8,
		PH_ISEC  = 4'd9,
		PH_NENT  = 4'd10,
		PH_ECODE = 4'd11,
		PH_ESIZE = 4'd12,
		PH_CSUM  = 4'd13,
		PH_PAY   = 4'd14,
		PH_CRC   = 4'd15
	} phase_t;

	typedef enum logic [3:0] {
		K_HDR_PLAIN     = 4'd0,
		K_HDR_V3        = 4'd1,
		K_HDR_WAVE      = 4'd2,
		K_HDR_WAVE_V3   = 4'd3,
		K_ENTRY         = 4'd4,
		K_PAYLOAD       = 4'd5,
		K_CHUNK_END     = 4'd6,
		K_STOP_VERSION  = 4'd7,
		K_STOP_TYPE     = 4'd8,
		K_STOP_CHECKSUM = 4'd9,
		K_STOP_TRUNC    = 4'd10
	} kind_t;

	typedef struct packed {
		logic [15:0] payload_len;
		logic [7:0]  family;
		logic [7:0]  family_rev;
		logic [7:0]  ext;
		logic [31:0] session_tag;
		logic [31:0] timestamp;
		logic [15:0] wave_intervals;
		logic [7:0]  wave_period;
	} header_t;

	// Results caused by one input byte: an optional main result and an
	// optional truncation stop that follows it.
	typedef struct packed {
		logic               has_main;
		logic               has_trunc;
		kind_t              kind;
		logic [7:0]         code;
		logic signed [15:0] size;
		header_t            hdr;
	} entry_t;

	typedef struct packed {
		kind_t              kind;
		header_t            hdr;
		logic [7:0]         code;
		logic signed [15:0] size;
		logic               last;
	} result_t;

	typedef struct packed {
		logic not_empty;
		logic not_full;
	} queue_status_t;

endpackage

// File: rtl/chunk_header_stream_parser.sv
// Top level of the chunk header stream parser.
// The parser takes one buffer byte per cycle whenever its internal queue
// has room, and a byte gives zero, one or two results (a truncation stop may
// follow a byte's own result). Results leave through a registered port at
// one per cycle while out_ready is high, so the sustained rate is one byte
// per cycle except where bytes cause two results; the result port is the
// limiting unit. A byte's first result is written into the queue and then
// loaded into the result register before it is presented on the result
// port. Header fields on every result show the current header registers,
// cleared by each version byte.
module chunk_header_stream_parser #(
	parameter int QUEUE_DEPTH = chsp_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               end_of_buffer,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         kind,
	output logic [15:0]        payload_len,
	output logic [7:0]         family,
	output logic [7:0]         family_rev,
	output logic [7:0]         ext,
	output logic [31:0]        session_tag,
	output logic [31:0]        timestamp,
	output logic [15:0]        wave_intervals,
	output logic [7:0]         wave_period,
	output logic [7:0]         entry_code,
	output logic signed [15:0] entry_size,
	output logic               last_of_run
);

	chsp_pkg::queue_status_t q_status;
	chsp_pkg::entry_t        push_entry, head;
	chsp_pkg::result_t       result;
	logic                    push, pop;

	chsp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_buffer(end_of_buffer),
		.q_status     (q_status),
		.push         (push),
		.push_entry   (push_entry)
	);

	chsp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	chsp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result   (result)
	);

	assign kind           = result.kind;
	assign payload_len    = result.hdr.payload_len;
	assign family         = result.hdr.family;
	assign family_rev     = result.hdr.family_rev;
	assign ext            = result.hdr.ext;
	assign session_tag    = result.hdr.session_tag;
	assign timestamp      = result.hdr.timestamp;
	assign wave_intervals = result.hdr.wave_intervals;
	assign wave_period    = result.hdr.wave_period;
	assign entry_code     = result.code;
	assign entry_size     = result.size;
	assign last_of_run    = result.last;

endmodule

// File: rtl/chsp_front.sv
// Front end: accepts bytes, tracks the chunk layout and queues the results.
module chsp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_buffer,
	input  chsp_pkg::queue_status_t q_status,
	output logic                  push,
	output chsp_pkg::entry_t      push_entry
);

	chsp_pkg::phase_t  phase_q, phase_n;
	logic [1:0]        fbi_q, fbi_n;
	logic [7:0]        sum_q, sum_n;
	logic              v3_q, v3_n, wave_q, wave_n, stopped_q, stopped_n;
	chsp_pkg::header_t hdr_q, hdr_n;
	logic [7:0]        entries_q, entries_n, ecode_q, ecode_n, elow_q, elow_n;
	logic [15:0]       payload_q, payload_n;
	logic [7:0]        entries_dec;
	logic              fire, has_main, has_trunc;
	chsp_pkg::kind_t   kind_main;
	logic [7:0]        code_main;
	logic [15:0]       size_main;

	assign in_ready    = q_status.not_full;
	assign fire        = in_valid && in_ready;
	assign entries_dec = entries_q - 8'd1;

	always_comb begin
		phase_n   = phase_q;
		fbi_n     = fbi_q;
		sum_n     = sum_q;
		v3_n      = v3_q;
		wave_n    = wave_q;
		stopped_n = stopped_q;
		hdr_n     = hdr_q;
		entries_n = entries_q;
		ecode_n   = ecode_q;
		elow_n    = elow_q;
		payload_n = payload_q;
		has_main  = 1'b0;
		has_trunc = 1'b0;
		kind_main = chsp_pkg::K_HDR_PLAIN;
		code_main = 8'd0;
		size_main = 16'd0;
		if (!stopped_q) begin
			if (phase_q != chsp_pkg::PH_CSUM && phase_q != chsp_pkg::PH_PAY &&
			    phase_q != chsp_pkg::PH_CRC) begin
				sum_n = sum_q + data_byte;
			end
			unique case (phase_q)
				chsp_pkg::PH_VER: begin
					sum_n  = data_byte;
					hdr_n  = '0;
					wave_n = 1'b0;
					fbi_n  = 2'd0;
					if (data_byte != chsp_pkg::VERSION_OLD &&
					    data_byte != chsp_pkg::VERSION_NEW) begin
						stopped_n = 1'b1;
						has_main  = 1'b1;
						kind_main = chsp_pkg::K_STOP_VERSION;
					end else begin
						v3_n    = (data_byte == chsp_pkg::VERSION_NEW);
						phase_n = chsp_pkg::PH_SIZE;
					end
				end
				chsp_pkg::PH_SIZE: begin
					hdr_n.payload_len[{fbi_q[0], 3'b000} +: 8] =
						hdr_q.payload_len[{fbi_q[0], 3'b000} +: 8] | data_byte;
					if (fbi_q != 2'd0) begin
						fbi_n   = 2'd0;
						phase_n = chsp_pkg::PH_TYPE;
					end else begin
						fbi_n = 2'd1;
					end
				end
				chsp_pkg::PH_TYPE: begin
					if (data_byte > chsp_pkg::TYPE_WAVEFORM) begin
						stopped_n = 1'b1;
						has_main  = 1'b1;
						kind_main = chsp_pkg::K_STOP_TYPE;
					end else begin
						wave_n  = (data_byte == chsp_pkg::TYPE_WAVEFORM);
						phase_n = chsp_pkg::PH_FAM;
					end
				end
				chsp_pkg::PH_FAM: begin
					hdr_n.family = data_byte;
					phase_n      = chsp_pkg::PH_FVER;
				end
				chsp_pkg::PH_FVER: begin
					hdr_n.family_rev = data_byte;
					phase_n          = chsp_pkg::PH_EXT;
				end
				chsp_pkg::PH_EXT: begin
					hdr_n.ext = data_byte;
					fbi_n     = 2'd0;
					phase_n   = chsp_pkg::PH_SID;
				end
				chsp_pkg::PH_SID: begin
					hdr_n.session_tag[{fbi_q, 3'b000} +: 8] =
						hdr_q.session_tag[{fbi_q, 3'b000} +: 8] | data_byte;
					if (fbi_q == 2'd3) begin
						fbi_n   = 2'd0;
						phase_n = chsp_pkg::PH_TIME;
					end else begin
						fbi_n = fbi_q + 2'd1;
					end
				end
				chsp_pkg::PH_TIME: begin
					hdr_n.timestamp[{fbi_q, 3'b000} +: 8] =
						hdr_q.timestamp[{fbi_q, 3'b000} +: 8] | data_byte;
					if (fbi_q == 2'd3) begin
						fbi_n = 2'd0;
						if (wave_q) begin
							phase_n = chsp_pkg::PH_ICNT;
						end else begin
							phase_n = v3_q ? chsp_pkg::PH_NENT : chsp_pkg::PH_CSUM;
						end
					end else begin
						fbi_n = fbi_q + 2'd1;
					end
				end
				chsp_pkg::PH_ICNT: begin
					hdr_n.wave_intervals[{fbi_q[0], 3'b000} +: 8] =
						hdr_q.wave_intervals[{fbi_q[0], 3'b000} +: 8] | data_byte;
					if (fbi_q != 2'd0) begin
						fbi_n   = 2'd0;
						phase_n = chsp_pkg::PH_ISEC;
					end else begin
						fbi_n = 2'd1;
					end
				end
				chsp_pkg::PH_ISEC: begin
					hdr_n.wave_period = data_byte;
					fbi_n   = 2'd0;
					phase_n = v3_q ? chsp_pkg::PH_NENT : chsp_pkg::PH_CSUM;
				end
				chsp_pkg::PH_NENT: begin
					entries_n = data_byte;
					phase_n   = (data_byte != 8'd0) ? chsp_pkg::PH_ECODE : chsp_pkg::PH_CSUM;
				end
				chsp_pkg::PH_ECODE: begin
					ecode_n = data_byte;
					fbi_n   = 2'd0;
					phase_n = chsp_pkg::PH_ESIZE;
				end
				chsp_pkg::PH_ESIZE: begin
					if (fbi_q == 2'd0) begin
						elow_n = data_byte;
						fbi_n  = 2'd1;
					end else begin
						fbi_n     = 2'd0;
						has_main  = 1'b1;
						kind_main = chsp_pkg::K_ENTRY;
						code_main = ecode_q;
						size_main = {data_byte, elow_q};
						entries_n = entries_dec;
						phase_n   = (entries_dec != 8'd0) ? chsp_pkg::PH_ECODE :
						            chsp_pkg::PH_CSUM;
					end
				end
				chsp_pkg::PH_CSUM: begin
					has_main = 1'b1;
					if (data_byte != sum_q) begin
						stopped_n = 1'b1;
						kind_main = chsp_pkg::K_STOP_CHECKSUM;
					end else begin
						kind_main = chsp_pkg::kind_t'({2'b00, wave_q, v3_q});
						payload_n = hdr_q.payload_len;
						fbi_n     = 2'd0;
						phase_n   = (hdr_q.payload_len != 16'd0) ? chsp_pkg::PH_PAY :
						            chsp_pkg::PH_CRC;
					end
				end
				chsp_pkg::PH_PAY: begin
					has_main  = 1'b1;
					kind_main = chsp_pkg::K_PAYLOAD;
					code_main = data_byte;
					payload_n = payload_q - 16'd1;
					if (payload_q == 16'd1) begin
						fbi_n   = 2'd0;
						phase_n = chsp_pkg::PH_CRC;
					end
				end
				chsp_pkg::PH_CRC: begin
					if (fbi_q == 2'd0) begin
						fbi_n = 2'd1;
					end else begin
						fbi_n     = 2'd0;
						has_main  = 1'b1;
						kind_main = chsp_pkg::K_CHUNK_END;
						phase_n   = chsp_pkg::PH_VER;
					end
				end
			endcase
			has_trunc = end_of_buffer && !stopped_n && phase_n != chsp_pkg::PH_VER;
		end
		// The end mark always re-arms the parser for the next buffer.
		if (end_of_buffer) begin
			stopped_n = 1'b0;
			phase_n   = chsp_pkg::PH_VER;
			fbi_n     = 2'd0;
			sum_n     = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= chsp_pkg::PH_VER;
			fbi_q     <= 2'd0;
			sum_q     <= 8'd0;
			v3_q      <= 1'b0;
			wave_q    <= 1'b0;
			stopped_q <= 1'b0;
			hdr_q     <= '0;
			entries_q <= 8'd0;
			ecode_q   <= 8'd0;
			elow_q    <= 8'd0;
			payload_q <= 16'd0;
		end else if (fire) begin
			phase_q   <= phase_n;
			fbi_q     <= fbi_n;
			sum_q     <= sum_n;
			v3_q      <= v3_n;
			wave_q    <= wave_n;
			stopped_q <= stopped_n;
			hdr_q     <= hdr_n;
			entries_q <= entries_n;
			ecode_q   <= ecode_n;
			elow_q    <= elow_n;
			payload_q <= payload_n;
		end
	end

	assign push                 = fire && (has_main || has_trunc);
	assign push_entry.has_main  = has_main;
	assign push_entry.has_trunc = has_trunc;
	assign push_entry.kind      = kind_main;
	assign push_entry.code      = code_main;
	assign push_entry.size      = size_main;
	assign push_entry.hdr       = hdr_n;

endmodule

// File: rtl/chsp_queue.sv
// Short register queue between the parser front end and the result back end.
module chsp_queue #(
	parameter int DEPTH = chsp_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  chsp_pkg::entry_t        push_entry,
	input  logic                    pop,
	output chsp_pkg::entry_t        head,
	output chsp_pkg::queue_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	chsp_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1)) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	assign head             = mem_q[rd_ptr_q];
	assign status.not_empty = (count_q != '0);
	assign status.not_full  = (count_q != CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/chsp_back.sv
// Back end: drains queued requests into the registered result port.
module chsp_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  chsp_pkg::entry_t        head,
	input  chsp_pkg::queue_status_t q_status,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output chsp_pkg::result_t       result
);

	logic              valid_q, pend_q, load;
	chsp_pkg::result_t res_q;

	assign load      = !valid_q || out_ready;
	assign pop       = load && !pend_q && q_status.not_empty;
	assign out_valid = valid_q;
	assign result    = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (q_status.not_empty) begin
				valid_q <= 1'b1;
				pend_q  <= head.has_main && head.has_trunc;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// A pending truncation stop reuses the header fields already on the port.
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				res_q.kind <= chsp_pkg::K_STOP_TRUNC;
				res_q.code <= 8'd0;
				res_q.size <= 16'sd0;
				res_q.last <= 1'b1;
			end else if (q_status.not_empty) begin
				res_q.hdr <= head.hdr;
				if (head.has_main) begin
					res_q.kind <= head.kind;
					res_q.code <= head.code;
					res_q.size <= head.size;
					res_q.last <= !head.has_trunc;
				end else begin
					res_q.kind <= chsp_pkg::K_STOP_TRUNC;
					res_q.code <= 8'd0;
					res_q.size <= 16'sd0;
					res_q.last <= 1'b1;
				end
			end
		end
	end

endmodule
